@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the lexer RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define JSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define JSL_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define JSL_ASSERT(lbl, prop, msg)
`define JSL_NEVER(lbl, expr, msg)
`endif
`endif

@@ hdl/jsl_pkg.sv @@
// ---------------------------------------------------------------------------
// jsl_pkg
// Types, codes and the keyword table of the lexer.
// ---------------------------------------------------------------------------
package jsl_pkg;

  localparam int KW_COUNT = 25;
  localparam int KW_THIS = 17;
  localparam int KW_SLOT = 16;
  localparam logic [23:0] MAX24 = 24'hFFFFFF;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_SLASH,
    M_SLASHSTAR, M_BLOCK, M_LINE, M_REGEX, M_FLAGS
  } mode_t;

  typedef enum logic [2:0] {
    K_IDENT = 3'd0, K_KEYWORD = 3'd1, K_NUMBER = 3'd2, K_STRING = 3'd3,
    K_OPERATOR = 3'd4, K_REGEX = 3'd5, K_DOC = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  kw;
    logic [23:0] off;
    logic [23:0] len;
    logic [7:0]  op;
    logic [23:0] line;
    logic        last;
  } tok_t;

  localparam logic [KW_SLOT*8-1:0] KW_TEXT [KW_COUNT] = '{
    "break", "case", "catch", "continue", "default", "delete", "do", "else",
    "finally", "for", "function", "if", "in", "instanceof", "new", "return",
    "switch", "this", "throw", "try", "typeof", "var", "void", "while", "with"
  };
  localparam int KW_LEN [KW_COUNT] = '{
    5, 4, 5, 8, 7, 6, 2, 4, 7, 3, 8, 2, 2, 10, 3, 6, 6, 4, 5, 3, 6, 3, 4, 5, 4
  };

  // byte k of keyword w, zero past its end
  function automatic logic [7:0] kw_char(input int w, input int k);
    logic [7:0] c;
    c = 8'd0;
    if (k < KW_LEN[w]) c = KW_TEXT[w][(KW_LEN[w]-1-k)*8 +: 8];
    return c;
  endfunction

endpackage

@@ hdl/jsl_kwmatch.sv @@
// ---------------------------------------------------------------------------
// jsl_kwmatch
// Parallel compare of the identifier buffer against all keywords.
// ---------------------------------------------------------------------------
module jsl_kwmatch #(
  parameter int KEYWORD_MAX_LEN = 10
) (
  input  logic [7:0] ibuf [KEYWORD_MAX_LEN],
  input  logic       overlong,
  output logic       hit,
  output logic [4:0] idx
);

  always_comb begin
    logic same;
    hit = 1'b0;
    idx = 5'd0;
    for (int w = jsl_pkg::KW_COUNT - 1; w >= 0; w--) begin
      same = 1'b1;
      for (int k = 0; k < KEYWORD_MAX_LEN; k++) begin
        if (ibuf[k] != jsl_pkg::kw_char(w, k)) same = 1'b0;
      end
      if (same && !overlong) begin
        hit = 1'b1;
        idx = 5'(w);
      end
    end
  end

endmodule

@@ hdl/jsl_scan.sv @@
// ---------------------------------------------------------------------------
// jsl_scan
// Scanner state and the per-byte next-state logic; yields up to two tokens.
// ---------------------------------------------------------------------------
module jsl_scan #(
  parameter int OFFSET_BITS = 24,
  parameter int KEYWORD_MAX_LEN = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             end_marker,
  output jsl_pkg::tok_t    rec0,
  output jsl_pkg::tok_t    rec1,
  output logic [1:0]       nrec
);

  localparam int OB = OFFSET_BITS;
  localparam int LW = OFFSET_BITS + 1;
  localparam int CW = $clog2(KEYWORD_MAX_LEN + 1);

  jsl_pkg::mode_t mode, mode_next;
  logic          regex_allowed, regex_allowed_next;
  logic [OB-1:0] byte_position, byte_position_next;
  logic [OB-1:0] token_start, token_start_next;
  logic [23:0]   newline_total, newline_total_next;
  logic [23:0]   doc_line, doc_line_next;
  logic [7:0]    ibuf [KEYWORD_MAX_LEN];
  logic [7:0]    ibuf_next [KEYWORD_MAX_LEN];
  logic [CW-1:0] icount, icount_next;
  logic          overlong, overlong_next;
  logic          dot_seen, dot_seen_next;
  logic          esc, esc_next;
  logic          in_class, in_class_next;
  logic          star_seen, star_seen_next;
  logic          is_doc, is_doc_next;
  logic          quote_kind, quote_kind_next;
  logic [7:0]    prev_byte, prev_byte_next;

  logic          kw_hit;
  logic [4:0]    kw_idx;

  jsl_kwmatch #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_kw (
    .ibuf(ibuf), .overlong(overlong), .hit(kw_hit), .idx(kw_idx)
  );

  function automatic logic [23:0] sat24(input logic [LW-1:0] v);
    return (33'(v) > 33'(jsl_pkg::MAX24)) ? jsl_pkg::MAX24 : 24'(v);
  endfunction

  function automatic jsl_pkg::tok_t mk(input jsl_pkg::kind_t k, input logic [4:0] w,
                                       input logic [LW-1:0] o, input logic [LW-1:0] l,
                                       input logic [7:0] op, input logic [23:0] ln);
    jsl_pkg::tok_t t;
    t.kind = k;
    t.kw   = w;
    t.off  = 24'(o);
    t.len  = sat24(l);
    t.op   = op;
    t.line = ln;
    t.last = 1'b0;
    return t;
  endfunction

  logic          b_alpha, b_digit, b_quote, b_ws;
  logic [LW-1:0] span, start_w;
  logic          a_v, b_v, idle_go;
  jsl_pkg::tok_t a_t, b_t, close_t;

  always_comb begin
    b_alpha = (data_byte >= "a" && data_byte <= "z") || (data_byte >= "A" && data_byte <= "Z")
              || data_byte == "_" || data_byte == "$";
    b_digit = data_byte >= "0" && data_byte <= "9";
    b_quote = data_byte == "\"" || data_byte == "'";
    b_ws    = data_byte == " " || data_byte == "\n" || data_byte == "\r" || data_byte == "\t";
    span    = {1'b0, byte_position - token_start};
    start_w = {1'b0, token_start};
    close_t = kw_hit ? mk(jsl_pkg::K_KEYWORD, kw_idx, start_w, span, 8'd0, 24'd0)
                     : mk(jsl_pkg::K_IDENT, 5'd0, start_w, span, 8'd0, 24'd0);
  end

  always_comb begin
    logic [LW-1:0] adj;
    mode_next = mode;
    regex_allowed_next = regex_allowed;
    byte_position_next = byte_position;
    token_start_next = token_start;
    newline_total_next = newline_total;
    doc_line_next = doc_line;
    ibuf_next = ibuf;
    icount_next = icount;
    overlong_next = overlong;
    dot_seen_next = dot_seen;
    esc_next = esc;
    in_class_next = in_class;
    star_seen_next = star_seen;
    is_doc_next = is_doc;
    quote_kind_next = quote_kind;
    prev_byte_next = prev_byte;
    a_v = 1'b0;
    b_v = 1'b0;
    a_t = close_t;
    b_t = close_t;
    idle_go = 1'b0;
    adj = '0;

    if (end_marker) begin
      unique case (mode)
        jsl_pkg::M_IDENT: a_v = 1'b1;
        jsl_pkg::M_NUMBER: begin
          a_v = 1'b1;
          a_t = mk(jsl_pkg::K_NUMBER, 5'd0, start_w, span, 8'd0, 24'd0);
        end
        jsl_pkg::M_STRING: begin
          adj = (prev_byte == "\"" || prev_byte == "'") ? LW'(2) : LW'(1);
          a_v = 1'b1;
          a_t = mk(jsl_pkg::K_STRING, 5'd0, start_w + LW'(1),
                   (span > adj) ? span - adj : '0, 8'd0, 24'd0);
        end
        jsl_pkg::M_SLASH: begin
          a_v = 1'b1;
          a_t = regex_allowed ? mk(jsl_pkg::K_REGEX, 5'd0, start_w, span, 8'd0, 24'd0)
                              : mk(jsl_pkg::K_OPERATOR, 5'd0, start_w, LW'(1), "/", 24'd0);
        end
        jsl_pkg::M_BLOCK: begin
          a_v = is_doc;
          a_t = mk(jsl_pkg::K_DOC, 5'd0, start_w, span, 8'd0, doc_line);
        end
        jsl_pkg::M_REGEX, jsl_pkg::M_FLAGS: begin
          a_v = 1'b1;
          a_t = mk(jsl_pkg::K_REGEX, 5'd0, start_w, span, 8'd0, 24'd0);
        end
        default: a_v = 1'b0;
      endcase
      mode_next = jsl_pkg::M_IDLE;
      regex_allowed_next = 1'b1;
      byte_position_next = '0;
      token_start_next = '0;
      newline_total_next = '0;
      doc_line_next = 24'd1;
      for (int k = 0; k < KEYWORD_MAX_LEN; k++) ibuf_next[k] = 8'd0;
      icount_next = '0;
      overlong_next = 1'b0;
      dot_seen_next = 1'b0;
      esc_next = 1'b0;
      in_class_next = 1'b0;
      star_seen_next = 1'b0;
      is_doc_next = 1'b0;
      quote_kind_next = 1'b0;
      prev_byte_next = 8'd0;
    end else begin
      unique case (mode)
        jsl_pkg::M_IDENT: begin
          if (b_alpha || b_digit) begin
            if (icount == CW'(KEYWORD_MAX_LEN)) overlong_next = 1'b1;
            else begin
              for (int k = 0; k < KEYWORD_MAX_LEN; k++)
                if (icount == CW'(k)) ibuf_next[k] = data_byte;
              icount_next = icount + CW'(1);
            end
          end else begin
            a_v = 1'b1;
            regex_allowed_next = kw_hit && (kw_idx != 5'(jsl_pkg::KW_THIS));
            idle_go = 1'b1;
          end
        end
        jsl_pkg::M_NUMBER: begin
          if (b_digit) begin
            mode_next = mode;
          end else if (data_byte == "." && !dot_seen) begin
            dot_seen_next = 1'b1;
          end else begin
            a_v = 1'b1;
            a_t = mk(jsl_pkg::K_NUMBER, 5'd0, start_w, span, 8'd0, 24'd0);
            regex_allowed_next = 1'b0;
            idle_go = 1'b1;
          end
        end
        jsl_pkg::M_STRING: begin
          if (esc) esc_next = 1'b0;
          else if (data_byte == "\\") esc_next = 1'b1;
          else if (data_byte == (quote_kind ? 8'h27 : 8'h22)) begin
            a_v = 1'b1;
            a_t = mk(jsl_pkg::K_STRING, 5'd0, start_w + LW'(1),
                     (span != '0) ? span - LW'(1) : '0, 8'd0, 24'd0);
            regex_allowed_next = 1'b1;
            mode_next = jsl_pkg::M_IDLE;
          end
        end
        jsl_pkg::M_SLASH: begin
          if (data_byte == "*") mode_next = jsl_pkg::M_SLASHSTAR;
          else if (data_byte == "/") mode_next = jsl_pkg::M_LINE;
          else if (regex_allowed) begin
            mode_next = jsl_pkg::M_REGEX;
            esc_next = (data_byte == "\\");
            in_class_next = (data_byte == "[");
          end else begin
            a_v = 1'b1;
            a_t = mk(jsl_pkg::K_OPERATOR, 5'd0, start_w, LW'(1), "/", 24'd0);
            regex_allowed_next = 1'b1;
            idle_go = 1'b1;
          end
        end
        jsl_pkg::M_SLASHSTAR: begin
          mode_next = jsl_pkg::M_BLOCK;
          is_doc_next = (data_byte == "*");
          star_seen_next = (data_byte == "*");
          if (data_byte == "*")
            doc_line_next = (newline_total == jsl_pkg::MAX24) ? jsl_pkg::MAX24
                                                              : newline_total + 24'd1;
        end
        jsl_pkg::M_BLOCK: begin
          if (star_seen && data_byte == "/") begin
            a_v = is_doc;
            a_t = mk(jsl_pkg::K_DOC, 5'd0, start_w, span + LW'(1), 8'd0, doc_line);
            is_doc_next = 1'b0;
            star_seen_next = 1'b0;
            mode_next = jsl_pkg::M_IDLE;
          end else star_seen_next = (data_byte == "*");
        end
        jsl_pkg::M_LINE: begin
          if (data_byte == "\n") mode_next = jsl_pkg::M_IDLE;
        end
        jsl_pkg::M_REGEX: begin
          if (esc) esc_next = 1'b0;
          else if (data_byte == "\\") esc_next = 1'b1;
          else if (in_class) begin
            if (data_byte == "]") in_class_next = 1'b0;
          end else if (data_byte == "[") in_class_next = 1'b1;
          else if (data_byte == "/") mode_next = jsl_pkg::M_FLAGS;
        end
        jsl_pkg::M_FLAGS: begin
          if (!(data_byte == "g" || data_byte == "i" || data_byte == "m")) begin
            a_v = 1'b1;
            a_t = mk(jsl_pkg::K_REGEX, 5'd0, start_w, span, 8'd0, 24'd0);
            regex_allowed_next = 1'b1;
            idle_go = 1'b1;
          end
        end
        default: idle_go = 1'b1;
      endcase

      // fresh scan of the byte between tokens
      if (idle_go) begin
        mode_next = jsl_pkg::M_IDLE;
        if (b_alpha) begin
          mode_next = jsl_pkg::M_IDENT;
          token_start_next = byte_position;
          for (int k = 0; k < KEYWORD_MAX_LEN; k++) ibuf_next[k] = 8'd0;
          ibuf_next[0] = data_byte;
          icount_next = CW'(1);
          overlong_next = 1'b0;
        end else if (b_digit) begin
          mode_next = jsl_pkg::M_NUMBER;
          token_start_next = byte_position;
          dot_seen_next = 1'b0;
        end else if (b_quote) begin
          mode_next = jsl_pkg::M_STRING;
          token_start_next = byte_position;
          quote_kind_next = (data_byte == "'");
          esc_next = 1'b0;
        end else if (data_byte == "/") begin
          mode_next = jsl_pkg::M_SLASH;
          token_start_next = byte_position;
        end else if (!b_ws) begin
          b_v = 1'b1;
          b_t = mk(jsl_pkg::K_OPERATOR, 5'd0, {1'b0, byte_position}, LW'(1), data_byte, 24'd0);
          regex_allowed_next = (data_byte != ")" && data_byte != "]");
        end
      end

      prev_byte_next = data_byte;
      if (data_byte == "\n" && newline_total != jsl_pkg::MAX24)
        newline_total_next = newline_total + 24'd1;
      if (byte_position != '1) byte_position_next = byte_position + OB'(1);
    end
  end

  always_comb begin
    rec0 = a_v ? a_t : b_t;
    rec1 = b_t;
    nrec = 2'(a_v) + 2'(b_v);
    rec0.last = !(a_v && b_v);
    rec1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= jsl_pkg::M_IDLE;
      regex_allowed <= 1'b1;
      byte_position <= '0;
      token_start <= '0;
      newline_total <= '0;
      doc_line <= 24'd1;
      for (int k = 0; k < KEYWORD_MAX_LEN; k++) ibuf[k] <= 8'd0;
      icount <= '0;
      overlong <= 1'b0;
      dot_seen <= 1'b0;
      esc <= 1'b0;
      in_class <= 1'b0;
      star_seen <= 1'b0;
      is_doc <= 1'b0;
      quote_kind <= 1'b0;
      prev_byte <= 8'd0;
    end else if (accept) begin
      mode <= mode_next;
      regex_allowed <= regex_allowed_next;
      byte_position <= byte_position_next;
      token_start <= token_start_next;
      newline_total <= newline_total_next;
      doc_line <= doc_line_next;
      ibuf <= ibuf_next;
      icount <= icount_next;
      overlong <= overlong_next;
      dot_seen <= dot_seen_next;
      esc <= esc_next;
      in_class <= in_class_next;
      star_seen <= star_seen_next;
      is_doc <= is_doc_next;
      quote_kind <= quote_kind_next;
      prev_byte <= prev_byte_next;
    end
  end

endmodule

@@ hdl/jsl_outq.sv @@
// ---------------------------------------------------------------------------
// jsl_outq
// Four-entry token queue: takes up to two tokens, hands out one per transfer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module jsl_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [1:0]    npush,
  input  jsl_pkg::tok_t wr0,
  input  jsl_pkg::tok_t wr1,
  input  logic          pop,
  output logic          full2,
  output logic          nonempty,
  output jsl_pkg::tok_t head
);

  jsl_pkg::tok_t mem [4];
  logic [1:0] rd_ptr, wr_ptr;
  logic [2:0] count;
  logic [1:0] nadd;

  assign nadd     = push ? npush : 2'd0;
  assign full2    = count > 3'd2;
  assign nonempty = count != 3'd0;
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (nadd != 2'd0) mem[wr_ptr] <= wr0;
    if (nadd == 2'd2) mem[wr_ptr + 2'd1] <= wr1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + nadd;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(nadd) - 3'(pop);
    end
  end

  `JSL_NEVER(a_no_overflow, count > 3'd4, "token queue overflow")
  `JSL_NEVER(a_pop_empty, pop && count == 3'd0, "pop from empty token queue")
  `JSL_ASSERT(a_count_track, 1'b1 |=> count == $past(count) + 3'($past(nadd)) - 3'($past(pop)), "queue count mismatch")

endmodule

@@ hdl/javascript_lexer.sv @@
// ---------------------------------------------------------------------------
// javascript_lexer
// JavaScript token scanner, one source byte per transfer.
// ---------------------------------------------------------------------------
// Input channel: data_byte / end_marker with in_valid / in_stall. One byte is
// taken per transfer; end_marker closes any open token and restarts offsets
// and line count from zero.
// Output channel: one token record per transfer with out_valid / out_stall;
// last_of_run marks the final token produced by an input byte.
// Throughput: one input byte per cycle while the queue has room. A byte yields
// zero, one or two tokens; tokens leave a four-entry queue at one per cycle
// while out_stall is low. With an empty queue a token is visible on the
// outputs in the cycle after its byte transfer.
// in_stall is high while the queue holds three or more tokens; a stalled
// receiver only fills the queue and never loses a token.
// Reset (rst, synchronous) empties the queue and puts the scanner between
// tokens with regex allowed.
// ---------------------------------------------------------------------------
module javascript_lexer #(
  parameter int OFFSET_BITS = 24,
  parameter int KEYWORD_MAX_LEN = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_marker,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  token_kind,
  output logic [4:0]  keyword_index,
  output logic [23:0] value_offset,
  output logic [23:0] value_length,
  output logic [7:0]  operator_byte,
  output logic [23:0] line_number,
  output logic        last_of_run
);

  logic          accept;
  logic [1:0]    nrec;
  jsl_pkg::tok_t rec0, rec1, head;
  logic          full2;

  assign in_stall = full2;
  assign accept   = in_valid && !full2;

  jsl_scan #(.OFFSET_BITS(OFFSET_BITS), .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_scan (
    .clk(clk), .rst(rst), .accept(accept), .data_byte(data_byte),
    .end_marker(end_marker), .rec0(rec0), .rec1(rec1), .nrec(nrec)
  );

  jsl_outq u_q (
    .clk(clk), .rst(rst), .push(accept), .npush(nrec), .wr0(rec0), .wr1(rec1),
    .pop(out_valid && !out_stall), .full2(full2), .nonempty(out_valid), .head(head)
  );

  assign token_kind    = head.kind;
  assign keyword_index = head.kw;
  assign value_offset  = head.off;
  assign value_length  = head.len;
  assign operator_byte = head.op;
  assign line_number   = head.line;
  assign last_of_run   = head.last;

endmodule
